// File: rtl/core/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants shared by the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

	localparam int CHAN_W   = 8;
	localparam int HUE_W    = 9;
	localparam int QUO_W    = 8;
	localparam int WORK_W   = 2 * QUO_W;
	localparam int HMUL_W   = 14;

	localparam int SAT_SCALE = 255;
	localparam int HUE_SCALE = 60;
	localparam int HUE_GREEN = 120;
	localparam int HUE_BLUE  = 240;
	localparam int HUE_FULL  = 360;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_out;
		logic [CHAN_W-1:0] sat_out;
		logic [CHAN_W-1:0] val_out;
	} hsv_t;

	typedef enum logic [1:0] {
		SEC_GREY,
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// sat_work/hue_work: remainder in the upper half, numerator bits and
	// quotient bits in the lower half
	typedef struct packed {
		logic [WORK_W-1:0] sat_work;
		logic [WORK_W-1:0] hue_work;
		logic [CHAN_W-1:0] delta;
		logic [CHAN_W-1:0] val;
		sector_t           sector;
		logic              neg;
	} stage_t;

endpackage

// File: rtl/core/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit RGB to integer HSV, one pixel per clock through a chain of divider cells
// while hsv_stall is low. Register stages: front stage, 8 cells, output register.
// Throughput: one pixel per cycle while unstalled, set by one quotient bit per cell.
// Reset clears all valid bits; no stored state beyond the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_stall,
	input  rth_pkg::pix_t pix,
	output logic          hsv_valid,
	input  logic          hsv_stall,
	output rth_pkg::hsv_t hsv
);
	import rth_pkg::*;

	stage_t link [0:QUO_W];
	logic   lvalid [0:QUO_W];
	logic   lready [0:QUO_W];
	logic   front_ready;

	logic [QUO_W-1:0] hq;
	logic [HUE_W-1:0] hue;
	hsv_t             res;
	hsv_t             hsv_q;
	logic             hsv_valid_q;

	rth_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_ready (front_ready),
		.up_data  (pix),
		.dn_valid (lvalid[0]),
		.dn_ready (lready[0]),
		.dn_data  (link[0])
	);

	assign pix_stall = !front_ready;

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		rth_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (lvalid[i]),
			.up_ready (lready[i]),
			.up_data  (link[i]),
			.dn_valid (lvalid[i+1]),
			.dn_ready (lready[i+1]),
			.dn_data  (link[i+1])
		);
	end

	always_comb begin
		hq = link[QUO_W].hue_work[QUO_W-1:0];
		case (link[QUO_W].sector)
			SEC_RED:   hue = (link[QUO_W].neg && hq != '0) ?
			                 HUE_W'(HUE_FULL) - HUE_W'(hq) : HUE_W'(hq);
			SEC_GREEN: hue = link[QUO_W].neg ? HUE_W'(HUE_GREEN) - HUE_W'(hq) :
			                 HUE_W'(HUE_GREEN) + HUE_W'(hq);
			SEC_BLUE:  hue = link[QUO_W].neg ? HUE_W'(HUE_BLUE) - HUE_W'(hq) :
			                 HUE_W'(HUE_BLUE) + HUE_W'(hq);
			default:   hue = '0;
		endcase
		res.hue_out = hue;
		res.sat_out = (link[QUO_W].sector == SEC_GREY) ? '0 :
		              link[QUO_W].sat_work[QUO_W-1:0];
		res.val_out = link[QUO_W].val;
	end

	assign lready[QUO_W] = !hsv_valid_q || !hsv_stall;
	assign hsv_valid     = hsv_valid_q;
	assign hsv           = hsv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (lready[QUO_W]) begin
			hsv_valid_q <= lvalid[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (lvalid[QUO_W] && lready[QUO_W]) begin
			hsv_q <= res;
		end
	end

endmodule

// File: rtl/core/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front
// Max/min search, hue sector select and divider numerators; one register stage.
// ----------------------------------------------------------------------------
module rth_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rth_pkg::pix_t  up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rth_pkg::stage_t dn_data
);
	import rth_pkg::*;

	logic [CHAN_W-1:0] r, g, b, mx, mn, delta, mag;
	logic signed [CHAN_W:0] diff;
	logic [HMUL_W-1:0] hnum;
	logic [WORK_W-1:0] snum;
	sector_t sector;
	stage_t  nxt;
	logic    valid_q;
	stage_t  data_s1;

	always_comb begin
		r  = up_data.red_in;
		g  = up_data.green_in;
		b  = up_data.blue_in;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		delta = mx - mn;
		if (delta == '0) begin
			sector = SEC_GREY;
			diff   = '0;
		end else if (r == mx) begin
			sector = SEC_RED;
			diff   = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g == mx) begin
			sector = SEC_GREEN;
			diff   = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			sector = SEC_BLUE;
			diff   = $signed({1'b0, r}) - $signed({1'b0, g});
		end
		mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
		hnum = HMUL_W'(mag) * HMUL_W'(HUE_SCALE);
		snum = WORK_W'(delta) * WORK_W'(SAT_SCALE);
		nxt.sat_work = snum;
		nxt.hue_work = WORK_W'(hnum);
		nxt.delta    = delta;
		nxt.val      = mx;
		nxt.sector   = sector;
		nxt.neg      = diff[CHAN_W];
	end

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: rtl/core/rth_cell.sv
// ----------------------------------------------------------------------------
// rth_cell
// One restoring division step for both the saturation and hue quotients.
// ----------------------------------------------------------------------------
module rth_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  rth_pkg::stage_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output rth_pkg::stage_t dn_data
);
	import rth_pkg::*;

	function automatic logic [WORK_W-1:0] div_step(
		input logic [WORK_W-1:0] work,
		input logic [CHAN_W-1:0] dvs
	);
		logic [QUO_W:0]   t;
		logic [QUO_W-1:0] rem;
		logic             q;
		t = {work[WORK_W-1:QUO_W], work[QUO_W-1]};
		if (t >= {1'b0, dvs}) begin
			rem = QUO_W'(t - {1'b0, dvs});
			q   = 1'b1;
		end else begin
			rem = t[QUO_W-1:0];
			q   = 1'b0;
		end
		return {rem, work[QUO_W-2:0], q};
	endfunction

	stage_t nxt;
	stage_t data_q;
	logic   valid_q;

	always_comb begin
		nxt          = up_data;
		nxt.sat_work = div_step(up_data.sat_work, up_data.val);
		nxt.hue_work = div_step(up_data.hue_work, up_data.delta);
	end

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

endmodule

// File: bench/rgb_to_hsv_pixel_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_test
// Drives RGB pixels into the converter and checks every HSV result in order
// against a behavioral conversion. Covers corner pixels, random streams under
// sender and receiver idling, a long output hold-off and input pauses.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_test;
	import rth_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RESET_TICKS = 11;
	localparam int PIPE_DEPTH  = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_TICKS  = 300;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic hsv_valid;
	logic hsv_stall;
	hsv_t hsv;

	hsv_t expected_hsv[$];
	int   mismatch_count;
	int   cycle_count;
	int   sender_idle_pct;
	int   recv_stall_pct;
	int   hold_left;

	rgb_to_hsv_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.hsv_valid (hsv_valid),
		.hsv_stall (hsv_stall),
		.hsv       (hsv)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic hsv_t convert_pixel(pix_t p);
		int r, g, b, v, lo, delta, s, h;
		hsv_t res;
		r = p.red_in;
		g = p.green_in;
		b = p.blue_in;
		v = (r > g) ? r : g;
		v = (v > b) ? v : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		delta = v - lo;
		s = (v != 0) ? (SAT_SCALE * delta) / v : 0;
		if (s == 0) begin
			h = 0;
		end else if (r == v) begin
			h = (HUE_SCALE * (g - b)) / delta;
			if (h < 0) begin
				h += HUE_FULL;
			end
		end else if (g == v) begin
			h = HUE_GREEN + (HUE_SCALE * (b - r)) / delta;
		end else begin
			h = HUE_BLUE + (HUE_SCALE * (r - g)) / delta;
		end
		res.hue_out = HUE_W'(h);
		res.sat_out = CHAN_W'(s);
		res.val_out = CHAN_W'(v);
		return res;
	endfunction

	function automatic pix_t make_pixel(int r, int g, int b);
		pix_t p;
		p.red_in   = CHAN_W'(r);
		p.green_in = CHAN_W'(g);
		p.blue_in  = CHAN_W'(b);
		return p;
	endfunction

	// mostly full-range channels, with greys, ties for largest and dim pixels mixed in
	function automatic pix_t random_pixel();
		pix_t p;
		int   v, lo;
		p = make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
		case ($urandom_range(7))
			0: begin
				v = $urandom_range(255);
				p = make_pixel(v, v, v);
			end
			1: begin
				v = $urandom_range(255);
				lo = $urandom_range(v);
				case ($urandom_range(2))
					0: p = make_pixel(v, v, lo);
					1: p = make_pixel(v, lo, v);
					default: p = make_pixel(lo, v, v);
				endcase
			end
			2: begin
				p = make_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	task automatic send_pixel(pix_t p);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			pix_valid <= 1'b0;
		end
		@(negedge clk);
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
		expected_hsv.push_back(convert_pixel(p));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_hsv.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stall, or a forced hold-off while hold_left runs down
	initial begin
		hsv_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hsv_stall <= 1'b1;
				hold_left--;
			end else begin
				hsv_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		hsv_t want;
		forever begin
			@(posedge clk);
			if (arst_n && hsv_valid && !hsv_stall) begin
				if (expected_hsv.size() == 0) begin
					report_mismatch("unexpected transfer, hsv", -1, int'(hsv));
				end else begin
					want = expected_hsv.pop_front();
					if (hsv.hue_out !== want.hue_out) begin
						report_mismatch("hue_out", want.hue_out, hsv.hue_out);
					end
					if (hsv.sat_out !== want.sat_out) begin
						report_mismatch("sat_out", want.sat_out, hsv.sat_out);
					end
					if (hsv.val_out !== want.val_out) begin
						report_mismatch("val_out", want.val_out, hsv.val_out);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_corner_pixels();
		pix_t corners[$];
		corners = '{
			make_pixel(0, 0, 0),
			make_pixel(255, 255, 255),
			make_pixel(128, 128, 128),
			make_pixel(1, 1, 1),
			make_pixel(255, 0, 0),
			make_pixel(0, 255, 0),
			make_pixel(0, 0, 255),
			make_pixel(255, 255, 0),
			make_pixel(255, 0, 255),
			make_pixel(0, 255, 255),
			make_pixel(255, 0, 1),
			make_pixel(200, 10, 190),
			make_pixel(1, 0, 0),
			make_pixel(0, 1, 0),
			make_pixel(0, 0, 1),
			make_pixel(1, 0, 1),
			make_pixel(254, 1, 0),
			make_pixel(85, 170, 1),
			make_pixel(170, 85, 254),
			make_pixel(3, 2, 1),
			make_pixel(100, 255, 254),
			make_pixel(7, 9, 200)
		};
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		foreach (corners[i]) begin
			send_pixel(corners[i]);
		end
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_stream(int count, int send_idle, int recv_idle);
		sender_idle_pct = send_idle;
		recv_stall_pct  = recv_idle;
		repeat (count) begin
			send_pixel(random_pixel());
		end
		stop_sending();
		wait_drained();
	endtask

	// hold the output for a long stretch while items keep coming, so the pipe backs up
	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left       = HOLD_TICKS;
		repeat (80) begin
			send_pixel(random_pixel());
		end
		stop_sending();
		wait_drained();
	endtask

	// short bursts, each followed by a pause until every result is back
	task automatic test_input_pause();
		sender_idle_pct = 0;
		recv_stall_pct  = 20;
		repeat (12) begin
			repeat ($urandom_range(1, 8)) begin
				send_pixel(random_pixel());
			end
			stop_sending();
			wait_drained();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		pix_valid       = 1'b0;
		pix             = '0;
		mismatch_count  = 0;
		cycle_count     = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left       = 0;
		repeat (RESET_TICKS) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_pixels();
		test_random_stream(300, 10, 57);
		test_random_stream(300, 57, 10);
		test_random_stream(300, 0, 0);
		test_output_backpressure();
		test_input_pause();

		wait_drained();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/rth_pkg.sv
rtl/core/rth_front.sv
rtl/core/rth_cell.sv
rtl/core/rgb_to_hsv_pixel.sv
bench/rgb_to_hsv_pixel_test.sv
